// ===== hw/rtl/sorted_digest_table_core_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted digest table assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_DIGEST_TABLE_CORE_ASSERT_SVH
`define SORTED_DIGEST_TABLE_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define SDT_ASSERT_HOLDS(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted digest table: property failed");

// next-cycle implication, off during reset
`define SDT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted digest table: property failed");

// next-cycle implication, live through reset
`define SDT_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sorted digest table: property failed");

`endif

// ===== hw/rtl/sdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted digest table package
// Result codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sdt_pkg;

   localparam int DIGEST_W = 64;
   localparam int VALUE_W  = 32;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_MATCH    = 2'd2,
      ST_NOMATCH  = 2'd3
   } status_type;

   typedef struct packed {
      logic       load;
      logic       rd_mid;
      logic       step;
      logic       ptr_count;
      logic       ptr_lo;
      logic       rd_below;
      logic       wr_shift;
      logic       wr_new;
      logic       rd_ptr;
      logic       ptr_inc;
      logic       save_prev;
      logic       emit;
      status_type emit_status;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic full;
      logic search_on;
      logic eq;
      logic shift_on;
      logic scan_on;
      logic prev_vld;
      logic out_free;
   } sts_type;

endpackage

// ===== hw/rtl/sdt_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted digest table datapath
// Entry memory, search bounds, pointer, held match and result register.
// ----------------------------------------------------------------------------
module sdt_datapath #(
   parameter int TABLE_DEPTH = 64,
   parameter int IDX_W       = 6,
   parameter int CNT_W       = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_mode,
   input  logic [63:0]              req_key_digest,
   input  logic [31:0]              req_entry_value,
   input  sdt_pkg::cmd_type         cmd,
   output sdt_pkg::sts_type         sts,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [31:0]              rsp_match_value,
   output logic                     rsp_last
);
   import sdt_pkg::*;

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   logic [DIGEST_W-1:0] dig_mem [TABLE_DEPTH];
   logic [VALUE_W-1:0]  val_mem [TABLE_DEPTH];

   logic                mode_ff;
   logic [DIGEST_W-1:0] key_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic                prev_vld_ff, prev_vld_in;
   logic [VALUE_W-1:0]  prev_val_ff;
   logic [DIGEST_W-1:0] rd_dig_ff;
   logic [VALUE_W-1:0]  rd_val_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic                rsp_last_ff;

   logic [CNT_W-1:0]    mid;
   logic [CNT_W-1:0]    ptr_dec;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [DIGEST_W-1:0] wr_dig;
   logic [VALUE_W-1:0]  wr_val;
   logic                out_free;

   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign ptr_dec  = ptr_ff - ONE_C;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rd_en   = cmd.rd_mid || cmd.rd_below || cmd.rd_ptr;
      rd_addr = ptr_ff[IDX_W-1:0];
      if (cmd.rd_mid) begin
         rd_addr = mid[IDX_W-1:0];
      end else if (cmd.rd_below) begin
         rd_addr = ptr_dec[IDX_W-1:0];
      end
      wr_en   = cmd.wr_shift || cmd.wr_new;
      wr_addr = ptr_ff[IDX_W-1:0];
      wr_dig  = rd_dig_ff;
      wr_val  = rd_val_ff;
      if (cmd.wr_new) begin
         wr_addr = lo_ff[IDX_W-1:0];
         wr_dig  = key_ff;
         wr_val  = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dig_mem[wr_addr] <= wr_dig;
         val_mem[wr_addr] <= wr_val;
      end
      if (rd_en) begin
         rd_dig_ff <= dig_mem[rd_addr];
         rd_val_ff <= val_mem[rd_addr];
      end
   end

   always_comb begin
      count_in    = count_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      ptr_in      = ptr_ff;
      prev_vld_in = prev_vld_ff;
      if (cmd.load) begin
         lo_in       = '0;
         hi_in       = count_ff;
         prev_vld_in = 1'b0;
      end
      if (cmd.step) begin
         if (rd_dig_ff < key_ff) begin
            lo_in = mid + ONE_C;
         end else begin
            hi_in = mid;
         end
      end
      if (cmd.ptr_count) begin
         ptr_in = count_ff;
      end else if (cmd.ptr_lo) begin
         ptr_in = lo_ff;
      end else if (cmd.wr_shift) begin
         ptr_in = ptr_dec;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + ONE_C;
      end
      if (cmd.wr_new) begin
         count_in = count_ff + ONE_C;
      end
      if (cmd.save_prev) begin
         prev_vld_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         ptr_ff       <= '0;
         prev_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         ptr_ff       <= ptr_in;
         prev_vld_ff  <= prev_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key_digest;
         value_ff <= req_entry_value;
      end
      if (cmd.save_prev) begin
         prev_val_ff <= rd_val_ff;
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_value_ff  <= (cmd.emit_status == ST_MATCH) ? prev_val_ff : '0;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   always_comb begin
      sts.mode      = mode_ff;
      sts.full      = (count_ff == DEPTH_C);
      sts.search_on = (lo_ff < hi_ff);
      sts.eq        = (rd_dig_ff == key_ff);
      sts.shift_on  = (ptr_ff > lo_ff);
      sts.scan_on   = (ptr_ff < count_ff);
      sts.prev_vld  = prev_vld_ff;
      sts.out_free  = out_free;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_match_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== hw/rtl/sdt_controller.sv =====
// ----------------------------------------------------------------------------
// Sorted digest table controller
// Sequences search, shift-insert and match scan over the datapath.
// ----------------------------------------------------------------------------
module sdt_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sdt_pkg::sts_type sts,
   output sdt_pkg::cmd_type cmd
);
   import sdt_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_CHECK    = 11'b000_0000_0010,
      S_SRCH     = 11'b000_0000_0100,
      S_SRCH_CMP = 11'b000_0000_1000,
      S_SHIFT    = 11'b000_0001_0000,
      S_SHIFT_WR = 11'b000_0010_0000,
      S_REP_FULL = 11'b000_0100_0000,
      S_REP_INS  = 11'b000_1000_0000,
      S_SCAN_RD  = 11'b001_0000_0000,
      S_SCAN_CHK = 11'b010_0000_0000,
      S_SCAN_END = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.emit_status = ST_INSERTED;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!sts.mode && sts.full) begin
               state_in = S_REP_FULL;
            end else begin
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (sts.search_on) begin
               cmd.rd_mid = 1'b1;
               state_in   = S_SRCH_CMP;
            end else if (!sts.mode) begin
               cmd.ptr_count = 1'b1;
               state_in      = S_SHIFT;
            end else begin
               cmd.ptr_lo = 1'b1;
               state_in   = S_SCAN_RD;
            end
         end
         S_SRCH_CMP: begin
            cmd.step = 1'b1;
            state_in = S_SRCH;
         end
         S_SHIFT: begin
            if (sts.shift_on) begin
               cmd.rd_below = 1'b1;
               state_in     = S_SHIFT_WR;
            end else begin
               cmd.wr_new = 1'b1;
               state_in   = S_REP_INS;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            state_in     = S_SHIFT;
         end
         S_REP_FULL: begin
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_FULL;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_REP_INS: begin
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_INSERTED;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_SCAN_RD: begin
            if (sts.scan_on) begin
               cmd.rd_ptr = 1'b1;
               state_in   = S_SCAN_CHK;
            end else begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_CHK: begin
            if (!sts.eq) begin
               state_in = S_SCAN_END;
            end else if (!sts.prev_vld) begin
               cmd.save_prev = 1'b1;
               cmd.ptr_inc   = 1'b1;
               state_in      = S_SCAN_RD;
            end else if (sts.out_free) begin
               // held match is not the final one
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_MATCH;
               cmd.save_prev   = 1'b1;
               cmd.ptr_inc     = 1'b1;
               state_in        = S_SCAN_RD;
            end
         end
         S_SCAN_END: begin
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = sts.prev_vld ? ST_MATCH : ST_NOMATCH;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== hw/rtl/sorted_digest_table_core.sv =====
// ----------------------------------------------------------------------------
// Sorted digest table core
// Multimap of (digest, value) pairs kept in ascending digest order.
// ----------------------------------------------------------------------------
// Request channel (req_*): mode 0 inserts key_digest/entry_value at the lower
// bound, so it sits before older entries of equal digest; mode 1 looks up all
// entries of that digest. A transfer is taken when req_valid is high and
// req_stall low; one request is in flight at a time.
// Response channel (rsp_*): an insert gives one transfer, status inserted or
// full. A lookup gives one match transfer per equal entry, newest first, with
// rsp_last on the final one, or a single no-match transfer.
// Flow: an accepted request is loaded, then an insert into a full table is
// reported at once; otherwise a binary search finds the lower bound in at most
// ceil(log2(N+1)) steps with N entries held. An insert then shifts the entries
// from the bound upward by one place, top entry first, and writes the new pair;
// a lookup reads forward from the bound while the digests match. The next
// request is taken in the cycle after the final transfer is loaded, so a new
// request is never taken before the previous one is through.
// While a valid result is stalled, the result register holds and the sequencer waits before loading another transfer.
// Reset empties the table by clearing the entry count; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_digest_table_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [63:0] req_key_digest,
   input  logic [31:0] req_entry_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_match_value,
   output logic        rsp_last
);
   import sdt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   cmd_type cmd;
   sts_type sts;

   sdt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sdt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_key_digest  (req_key_digest),
      .req_entry_value (req_entry_value),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_match_value (rsp_match_value),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== hw/rtl/sdt_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted digest table checker
// Port-level properties of the response channel, bound to the core.
// ----------------------------------------------------------------------------
`include "sorted_digest_table_core_assert.svh"

module sdt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_match_value,
   input logic        rsp_last
);
   import sdt_pkg::*;

   `SDT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_match_value) && $stable(rsp_last))

   `SDT_ASSERT_HOLDS(a_single_rsp, clock, reset, rsp_valid && (rsp_status != ST_MATCH), rsp_last && (rsp_match_value == 32'd0))

   `SDT_ASSERT_HOLDS(a_mid_is_match, clock, reset, rsp_valid && !rsp_last, rsp_status == ST_MATCH)

   `SDT_ASSERT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid)

endmodule

bind sorted_digest_table_core sdt_checker u_sdt_chk (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_match_value (rsp_match_value),
   .rsp_last        (rsp_last)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Sorted digest table core testbench
// Drives insert and lookup requests with random idle gaps on the request
// side and random stalls on the response side. A local model of the sorted
// multimap predicts each response transfer unless a directed row types its
// status; observed transfers are compared field by field in order. A short
// table of directed requests comes first, then random requests mostly drawn
// from a small pool of hot digests, so equal-digest runs and a full table occur.
// ----------------------------------------------------------------------------
module tb;
   import sdt_pkg::*;

   localparam int DEPTH       = 64;
   localparam int ITEMS       = 400;
   localparam int MAX_CYCLES  = 10_000_000;
   localparam int TAIL_CYCLES = 300;
   localparam int N_DIR       = 22;
   localparam int POOL_SIZE   = 8;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   typedef struct packed {
      status_type  status;
      logic [31:0] value;
      logic        last;
   } rsp_item_type;

   typedef struct {
      logic        mode;
      logic [63:0] key;
      logic [31:0] value;
      bit          typed;
      status_type  status;
   } stim_row_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic        req_mode        = MODE_INSERT;
   logic [63:0] req_key_digest  = '0;
   logic [31:0] req_entry_value = '0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_match_value;
   logic        rsp_last;

   // typed expectation travelling with the current request
   bit          row_typed  = 1'b0;
   status_type  row_status = ST_NOMATCH;
   bit          calm       = 1'b0;

   logic [63:0] held_digest [DEPTH];
   logic [31:0] held_value  [DEPTH];
   int unsigned held_count = 0;
   rsp_item_type model_out[$];
   rsp_item_type pending_rsp[$];

   int unsigned fails = 0;
   int unsigned cycles = 0;
   int unsigned n_requests = 0, n_inserted = 0, n_rejected = 0, n_lookups = 0;
   int unsigned n_matches = 0, n_misses = 0, deepest_run = 0;

   logic [63:0] key_pool [POOL_SIZE];

   stim_row_type dir_rows [N_DIR] = '{
      '{MODE_LOOKUP, 64'h0000_0000_0000_0000, 32'h0000_0000, 1'b1, ST_NOMATCH},
      '{MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_NOMATCH},
      '{MODE_INSERT, 64'h0000_0000_0000_0005, 32'hAAAA_AAAA, 1'b1, ST_INSERTED},
      '{MODE_INSERT, 64'h0000_0000_0000_0000, 32'h0000_0000, 1'b1, ST_INSERTED},
      '{MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_INSERTED},
      '{MODE_INSERT, 64'h0000_0000_0000_0005, 32'h5555_5555, 1'b1, ST_INSERTED},
      '{MODE_INSERT, 64'h0000_0000_0000_0005, 32'h0000_0001, 1'b1, ST_INSERTED},
      '{MODE_LOOKUP, 64'h0000_0000_0000_0005, 32'h0000_0000, 1'b0, ST_MATCH},
      '{MODE_LOOKUP, 64'h0000_0000_0000_0000, 32'h0000_0000, 1'b0, ST_MATCH},
      '{MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b0, ST_MATCH},
      '{MODE_LOOKUP, 64'h0000_0000_0000_0004, 32'h0000_0000, 1'b1, ST_NOMATCH},
      '{MODE_LOOKUP, 64'h0000_0000_0000_0006, 32'h0000_0000, 1'b1, ST_NOMATCH},
      '{MODE_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b1, ST_INSERTED},
      '{MODE_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b1, ST_INSERTED},
      '{MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_1234, 1'b1, ST_INSERTED},
      '{MODE_INSERT, 64'h0000_0000_0000_0000, 32'h0000_DEAD, 1'b1, ST_INSERTED},
      '{MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b0, ST_MATCH},
      '{MODE_LOOKUP, 64'h0000_0000_0000_0000, 32'h0000_0000, 1'b0, ST_MATCH},
      '{MODE_LOOKUP, 64'h8000_0000_0000_0000, 32'h0000_0000, 1'b0, ST_MATCH},
      '{MODE_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b0, ST_MATCH},
      '{MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 32'h0000_0000, 1'b1, ST_NOMATCH},
      '{MODE_LOOKUP, 64'h0000_0000_0000_0001, 32'h0000_0000, 1'b1, ST_NOMATCH}
   };

   sorted_digest_table_core #(
      .TABLE_DEPTH(DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_key_digest(req_key_digest),
      .req_entry_value(req_entry_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_match_value(rsp_match_value),
      .rsp_last(rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= MAX_CYCLES) begin
         $display("FAIL sorted_digest_table_core");
         $finish;
      end
   end

   function automatic int unsigned find_slot(logic [63:0] key);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = held_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (held_digest[mid] < key) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic void model_request(logic mode, logic [63:0] key, logic [31:0] value);
      int unsigned pos, i, n;
      model_out.delete();
      if (mode == MODE_INSERT) begin
         if (held_count >= DEPTH) begin
            model_out.insert(model_out.size(), rsp_item_type'{ST_FULL, 32'd0, 1'b1});
            n_rejected++;
         end else begin
            pos = find_slot(key);
            for (i = held_count; i > pos; i--) begin
               held_digest[i] = held_digest[i - 1];
               held_value[i]  = held_value[i - 1];
            end
            held_digest[pos] = key;
            held_value[pos]  = value;
            held_count++;
            model_out.insert(model_out.size(), rsp_item_type'{ST_INSERTED, 32'd0, 1'b1});
            n_inserted++;
         end
      end else begin
         n_lookups++;
         pos = find_slot(key);
         n = 0;
         for (i = pos; i < held_count && held_digest[i] == key; i++) begin
            model_out.insert(model_out.size(),
                             rsp_item_type'{ST_MATCH, held_value[i], 1'b0});
            n++;
         end
         if (n == 0) begin
            model_out.insert(model_out.size(), rsp_item_type'{ST_NOMATCH, 32'd0, 1'b1});
            n_misses++;
         end else begin
            model_out[n - 1].last = 1'b1;
            n_matches += n;
            if (n > deepest_run) deepest_run = n;
         end
      end
   endfunction

   // request capture first, so a prediction is queued before any response check
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            n_requests++;
            model_request(req_mode, req_key_digest, req_entry_value);
            if (row_typed) pending_rsp.insert(pending_rsp.size(),
                                              rsp_item_type'{row_status, 32'd0, 1'b1});
            else foreach (model_out[k]) pending_rsp.insert(pending_rsp.size(), model_out[k]);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $error("response transfer with nothing expected: status %0d value %h last %b",
                      rsp_status, rsp_match_value, rsp_last);
               fails++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fails++;
               end
               if (rsp_match_value !== want.value) begin
                  $error("match_value: expected %h, got %h", want.value, rsp_match_value);
                  fails++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_last);
                  fails++;
               end
            end
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0 && !calm) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = calm ? 0 : pick_gap();
         end
      end
   end

   task automatic send_req(input stim_row_type row);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_mode        <= row.mode;
      req_key_digest  <= row.key;
      req_entry_value <= row.value;
      row_typed       <= row.typed;
      row_status      <= row.status;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_req(input int unsigned gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      stim_row_type row;
      int unsigned  r;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIR; i++) begin
         send_req(dir_rows[i]);
         idle_req(pick_gap());
      end

      key_pool[0] = 64'h0000_0000_0000_0000;
      key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
      key_pool[2] = 64'h0000_0000_0000_0005;
      for (int p = 3; p < POOL_SIZE; p++) key_pool[p] = {$urandom, $urandom};

      for (int i = 0; i < ITEMS; i++) begin
         if (i == 150) drain();
         calm = (i >= 200 && i < 260);
         r = $urandom_range(99);
         row.mode   = ($urandom_range(99) < (held_count < DEPTH ? 55 : 25))
                      ? MODE_INSERT : MODE_LOOKUP;
         row.value  = $urandom;
         row.typed  = 1'b0;
         row.status = ST_MATCH;
         if (r < 60) row.key = key_pool[$urandom_range(POOL_SIZE - 1)];
         else if (r < 75) row.key = key_pool[$urandom_range(POOL_SIZE - 1)]
                                    + ($urandom_range(1) ? 64'd1 : -64'd1);
         else row.key = {$urandom, $urandom};
         send_req(row);
         if (!calm) idle_req(pick_gap());
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d inserts, %0d rejected on a full table, %0d lookups",
               n_requests, n_inserted, n_rejected, n_lookups);
      $display("Lookups gave %0d match transfers and %0d misses, longest equal run %0d",
               n_matches, n_misses, deepest_run);
      if (fails == 0) begin
         $display("PASS sorted_digest_table_core");
      end else begin
         $display("FAIL sorted_digest_table_core");
      end
      $finish;
   end

endmodule
